>>> src/msf_pkg.sv
// shared types and constants for the monochrome page frame store with shape fill
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package msf_pkg;

  localparam int PIXELS_WIDE = 128;
  localparam int PIXELS_HIGH = 64;
  localparam int PAGE_ROWS   = 8;
  localparam int PAGE_COUNT  = (PIXELS_HIGH + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = PIXELS_WIDE * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // x bounds run 0..PIXELS_WIDE, y bounds 0..PAGE_COUNT*PAGE_ROWS
  localparam int XB_W = $clog2(PIXELS_WIDE + 1);
  localparam int YB_W = $clog2(PAGE_COUNT * PAGE_ROWS + 1);
  localparam int PG_W = YB_W - 3;

  // signed working width for coordinate arithmetic
  localparam int CO_W = 13;

  // field widths fixed by the command format
  localparam int RADDR_W = 10;
  localparam int RA_W    = (ADDR_W > RADDR_W) ? ADDR_W : RADDR_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [XB_W-1:0] X_END = XB_W'(PIXELS_WIDE);
  localparam logic [YB_W-1:0] Y_END = YB_W'(PAGE_COUNT * PAGE_ROWS);

  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_PIXEL  = 3'd1;
  localparam logic [2:0] FUNC_RECT   = 3'd2;
  localparam logic [2:0] FUNC_CIRCLE = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  typedef enum logic [0:0] {
    JOB_FILL,
    JOB_READ
  } job_kind_t;

  // one classified command: a clipped box to walk, or a byte read
  typedef struct packed {
    job_kind_t           kind;
    logic                circle;
    logic                ink;
    logic [XB_W-1:0]     xlo;
    logic [XB_W-1:0]     xhi;
    logic [YB_W-1:0]     ylo;
    logic [YB_W-1:0]     yhi;
    logic signed [10:0]  cx;
    logic signed [10:0]  cy;
    logic [6:0]          r;
    logic [ADDR_W-1:0]   raddr;
    logic                rok;
  } job_t;

endpackage

>>> src/mono_framebuffer_shape_fill.sv
// top level of the monochrome page frame store with rectangle and circle fill
// depends on msf_pkg, msf_front, msf_queue, msf_back
`timescale 1ns / 1ps

// channel   | dir | handshake                         | fields
// command   | in  | start, taken when start && !busy  | func pos_x pos_y rect_width
//           |     |                                   | rect_height radius ink read_address
// read data | out | done, one-cycle strobe, no stall  | read_data
//
// an item is taken while the two-entry job queue has room and no reset clear runs.
// fills walk the clipped box one store byte a cycle, column by column within each page,
// then drain the pipeline; a full clear walks all STORE_BYTES (1024) bytes. a circle
// walks its clipped box of up to 2r+1 columns over its page span; a read passes the
// read and response states after it leaves the queue before done. after reset the store
// is cleared by the same walk, with busy held high. done cannot be held off by the receiver.

module mono_framebuffer_shape_fill import msf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          func,
  input  logic signed [10:0]  pos_x,
  input  logic signed [10:0]  pos_y,
  input  logic [9:0]          rect_width,
  input  logic [9:0]          rect_height,
  input  logic [6:0]          radius,
  input  logic                ink,
  input  logic [9:0]          read_address,
  output logic                done,
  output logic [7:0]          read_data
);

  job_t new_job;
  job_t head;
  logic push, pop, q_full, q_empty, init_clear;

  msf_front u_front (
    .start        (start),
    .func         (func),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .radius       (radius),
    .ink          (ink),
    .read_address (read_address),
    .q_full       (q_full),
    .init_clear   (init_clear),
    .busy         (busy),
    .push         (push),
    .job          (new_job)
  );

  msf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (new_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  msf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .init_clear (init_clear),
    .done       (done),
    .read_data  (read_data)
  );

endmodule

>>> src/msf_front.sv
// command front end: decodes an item, clips its shape to the screen and builds a job
// depends on msf_pkg
`timescale 1ns / 1ps

module msf_front import msf_pkg::*; (
  input  logic                start,
  input  logic [2:0]          func,
  input  logic signed [10:0]  pos_x,
  input  logic signed [10:0]  pos_y,
  input  logic [9:0]          rect_width,
  input  logic [9:0]          rect_height,
  input  logic [6:0]          radius,
  input  logic                ink,
  input  logic [9:0]          read_address,
  input  logic                q_full,
  input  logic                init_clear,
  output logic                busy,
  output logic                push,
  output job_t                job
);

  localparam logic signed [CO_W-1:0] ONE   = CO_W'(1);
  localparam logic signed [CO_W-1:0] ZERO  = '0;
  localparam logic signed [CO_W-1:0] X_LIM = CO_W'(PIXELS_WIDE);
  localparam logic signed [CO_W-1:0] Y_LIM = CO_W'(PIXELS_HIGH);

  logic signed [CO_W-1:0] sx, sy, w13, h13, r13;
  logic signed [CO_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [CO_W-1:0] cl_xlo, cl_xhi, cl_ylo, cl_yhi;
  logic                   draw, clr, rd, empty_box;
  logic [RA_W-1:0]        ra_ext;

  assign busy = q_full || init_clear;

  always_comb begin
    sx     = {{(CO_W-11){pos_x[10]}}, pos_x};
    sy     = {{(CO_W-11){pos_y[10]}}, pos_y};
    w13    = CO_W'(rect_width);
    h13    = CO_W'(rect_height);
    r13    = CO_W'(radius);
    lo_x   = ZERO;
    hi_x   = ZERO;
    lo_y   = ZERO;
    hi_y   = ZERO;
    draw   = 1'b0;
    clr    = 1'b0;
    rd     = 1'b0;
    unique case (func)
      FUNC_CLEAR: clr = 1'b1;
      FUNC_PIXEL: begin
        draw = 1'b1;
        lo_x = sx;
        hi_x = sx + ONE;
        lo_y = sy;
        hi_y = sy + ONE;
      end
      FUNC_RECT: begin
        draw = 1'b1;
        lo_x = sx;
        hi_x = sx + w13;
        lo_y = sy;
        hi_y = sy + h13;
      end
      FUNC_CIRCLE: begin
        draw = 1'b1;
        lo_x = sx - r13;
        hi_x = sx + r13 + ONE;
        lo_y = sy - r13;
        hi_y = sy + r13 + ONE;
      end
      FUNC_READ: rd = 1'b1;
      default: ;
    endcase

    cl_xlo    = (lo_x < ZERO) ? ZERO : lo_x;
    cl_xhi    = (hi_x > X_LIM) ? X_LIM : hi_x;
    cl_ylo    = (lo_y < ZERO) ? ZERO : lo_y;
    cl_yhi    = (hi_y > Y_LIM) ? Y_LIM : hi_y;
    empty_box = (cl_xlo >= cl_xhi) || (cl_ylo >= cl_yhi);

    ra_ext     = RA_W'(read_address);
    job.kind   = rd ? JOB_READ : JOB_FILL;
    job.circle = (func == FUNC_CIRCLE);
    job.ink    = ink;
    job.xlo    = cl_xlo[XB_W-1:0];
    job.xhi    = cl_xhi[XB_W-1:0];
    job.ylo    = cl_ylo[YB_W-1:0];
    job.yhi    = cl_yhi[YB_W-1:0];
    job.cx     = pos_x;
    job.cy     = pos_y;
    job.r      = radius;
    job.raddr  = ra_ext[ADDR_W-1:0];
    job.rok    = (32'(read_address) < 32'(STORE_BYTES));
    // clear walks whole bytes, including any rows below the screen in the last page
    if (clr) begin
      job.circle = 1'b0;
      job.ink    = 1'b0;
      job.xlo    = '0;
      job.xhi    = X_END;
      job.ylo    = '0;
      job.yhi    = Y_END;
    end

    push = start && !busy && (clr || rd || (draw && !empty_box));
  end

endmodule

>>> src/msf_queue.sv
// short job queue between the front end and the draw engine
// depends on msf_pkg
`timescale 1ns / 1ps

module msf_queue import msf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t            slots [Q_DEPTH];
  logic [Q_PW-1:0] wp;
  logic [Q_PW-1:0] rp;
  logic [Q_CW-1:0] cnt;

  assign full  = (cnt == Q_CW'(Q_DEPTH));
  assign empty = (cnt == '0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == Q_PW'(Q_DEPTH - 1)) ? '0 : wp + Q_PW'(1);
      end
      if (pop) begin
        rp <= (rp == Q_PW'(Q_DEPTH - 1)) ? '0 : rp + Q_PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + Q_CW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - Q_CW'(1);
      end
    end
  end

endmodule

>>> src/msf_back.sv
// draw engine: walks a job's clipped box byte by byte with read-modify-write
// on the frame store, and serves byte reads; depends on msf_pkg
`timescale 1ns / 1ps

module msf_back import msf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       init_clear,
  output logic       done,
  output logic [7:0] read_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_READ,
    S_RESP
  } state_t;

  state_t            state;
  job_t              job;
  logic [13:0]       rsq;
  logic [XB_W-1:0]   x;
  logic [XB_W-1:0]   x_last;
  logic [PG_W-1:0]   page;
  logic [PG_W-1:0]   pg_last;
  logic [ADDR_W-1:0] base;

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        mem_q;
  logic [ADDR_W-1:0] rd_addr;

  // issue stage
  logic                    issue;
  logic [7:0]              a_rowok;
  logic [6:0]              a_dya [PAGE_ROWS];
  logic [6:0]              a_dxa;
  logic [YB_W-1:0]         a_y;
  logic signed [CO_W-1:0]  a_dy;
  logic signed [CO_W-1:0]  a_dyabs;
  logic signed [CO_W-1:0]  a_dx;
  logic signed [CO_W-1:0]  a_dxabs;
  logic signed [CO_W-1:0]  cx13, cy13;

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  logic [6:0]        s1_dxa;
  logic [6:0]        s1_dya [PAGE_ROWS];
  logic [7:0]        s1_rowok;

  logic              s2_valid;
  logic [ADDR_W-1:0] s2_addr;
  logic [13:0]       s2_dxsq;
  logic [13:0]       s2_dysq [PAGE_ROWS];
  logic [7:0]        s2_rowok;
  logic [7:0]        s2_data;

  logic [7:0]        mask;
  logic [7:0]        wdata;
  logic [14:0]       dsq_sum;
  logic [YB_W-1:0]   yhi_m1;

  assign pop     = (state == S_IDLE) && !empty;
  assign issue   = (state == S_SCAN);
  assign rd_addr = (state == S_READ) ? job.raddr : base + ADDR_W'(x);
  assign yhi_m1  = head.yhi - YB_W'(1);

  // per-row box and circle tests for the byte being issued
  always_comb begin
    cx13    = {{(CO_W-11){job.cx[10]}}, job.cx};
    cy13    = {{(CO_W-11){job.cy[10]}}, job.cy};
    a_dx    = CO_W'(x) - cx13;
    a_dxabs = (a_dx < 0) ? -a_dx : a_dx;
    a_dxa   = a_dxabs[6:0];
    a_y     = '0;
    a_dy    = '0;
    a_dyabs = '0;
    for (int k = 0; k < PAGE_ROWS; k++) begin
      a_y        = {page, 3'(k)};
      a_dy       = CO_W'(a_y) - cy13;
      a_dyabs    = (a_dy < 0) ? -a_dy : a_dy;
      a_dya[k]   = a_dyabs[6:0];
      a_rowok[k] = (a_y >= job.ylo) && (a_y < job.yhi) &&
                   (!job.circle || (a_dyabs <= CO_W'(job.r)));
    end
  end

  always_comb begin
    dsq_sum = '0;
    for (int k = 0; k < PAGE_ROWS; k++) begin
      dsq_sum = 15'(s2_dxsq) + 15'(s2_dysq[k]);
      mask[k] = s2_rowok[k] && (!job.circle || (dsq_sum <= 15'(rsq)));
    end
    wdata = job.ink ? (s2_data | mask) : (s2_data & ~mask);
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (s2_valid) begin
      mem[s2_addr] <= wdata;
    end
  end

  // datapath registers of the two pipeline stages
  always_ff @(posedge clk) begin
    s1_addr  <= rd_addr;
    s1_dxa   <= a_dxa;
    s1_rowok <= a_rowok;
    for (int k = 0; k < PAGE_ROWS; k++) begin
      s1_dya[k]  <= a_dya[k];
      s2_dysq[k] <= 14'(s1_dya[k]) * 14'(s1_dya[k]);
    end
    s2_addr  <= s1_addr;
    s2_dxsq  <= 14'(s1_dxa) * 14'(s1_dxa);
    s2_rowok <= s1_rowok;
    s2_data  <= mem_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // reset starts a full-store clear walk
      state      <= S_SCAN;
      init_clear <= 1'b1;
      done       <= 1'b0;
      read_data  <= '0;
      job.kind   <= JOB_FILL;
      job.circle <= 1'b0;
      job.ink    <= 1'b0;
      job.xlo    <= '0;
      job.xhi    <= X_END;
      job.ylo    <= '0;
      job.yhi    <= Y_END;
      job.cx     <= '0;
      job.cy     <= '0;
      job.r      <= '0;
      job.raddr  <= '0;
      job.rok    <= 1'b0;
      rsq        <= '0;
      x          <= '0;
      x_last     <= X_END - XB_W'(1);
      page       <= '0;
      pg_last    <= PG_W'(PAGE_COUNT - 1);
      base       <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            job     <= head;
            rsq     <= 14'(head.r) * 14'(head.r);
            x       <= head.xlo;
            x_last  <= head.xhi - XB_W'(1);
            page    <= head.ylo[YB_W-1:3];
            pg_last <= yhi_m1[YB_W-1:3];
            base    <= ADDR_W'(int'(head.ylo[YB_W-1:3]) * PIXELS_WIDE);
            state   <= (head.kind == JOB_READ) ? S_READ : S_SCAN;
          end
        end
        S_SCAN: begin
          if (x == x_last) begin
            x <= job.xlo;
            if (page == pg_last) begin
              state <= S_DRAIN;
            end else begin
              page <= page + PG_W'(1);
              base <= base + ADDR_W'(PIXELS_WIDE);
            end
          end else begin
            x <= x + XB_W'(1);
          end
        end
        S_DRAIN: begin
          // last write must land before the next job reads the store
          if (!s1_valid && !s2_valid) begin
            state      <= S_IDLE;
            init_clear <= 1'b0;
          end
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_RESP: begin
          done      <= 1'b1;
          read_data <= job.rok ? mem_q : 8'h00;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_after_resp: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RESP))
    else $error("result strobe without a read response cycle");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!s1_valid && !s2_valid))
    else $error("new job can start while writes are still in flight");

  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_RESP) |-> !s2_valid)
    else $error("store write overlaps a byte read");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!empty && !init_clear))
    else $error("job taken from empty queue or during reset clear");

endmodule
